FILE: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every edge outside reset
`define GRR_ASSERT_ON(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// property checked on every edge, reset included
`define GRR_ASSERT_ALL(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/grr_pkg.sv
package grr_pkg;

  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] GROUP_SIZE_RESET = 5'd2;

  // bank handed back by the drain side once all its reads are issued
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

  // zero acts as one, anything above max_group saturates
  function automatic logic [CFG_W-1:0] eff_group(input logic [CFG_W-1:0] gs,
                                                 input int unsigned max_group);
    logic [CFG_W-1:0] k;
    if (gs == '0) begin
      k = CFG_W'(1);
    end else if (32'(gs) > max_group) begin
      k = CFG_W'(max_group);
    end else begin
      k = gs;
    end
    return k;
  endfunction

endpackage

FILE: hw/rtl/grr_ram.sv
module grr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/grr_fifo.sv
module grr_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slot [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       cnt;
  logic             push;
  logic             pop;

  assign push_ready = (cnt != 2'd2);
  assign pop_valid  = (cnt != 2'd0);
  assign pop_data   = slot[rptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/grr_front.sv
module grr_front #(
  parameter int MAX_GROUP  = 16,
  parameter int WORD_WIDTH = 32,
  parameter int AW         = 4,
  parameter int CW         = 5,
  parameter int DW         = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [grr_pkg::CFG_W-1:0]  group_size,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [WORD_WIDTH-1:0]      word_in,
  input  logic                       final_in,
  output logic                       ram_we,
  output logic [AW:0]                ram_waddr,
  output logic [WORD_WIDTH-1:0]      ram_wdata,
  output logic                       desc_valid,
  input  logic                       desc_ready,
  output logic [DW-1:0]              desc,
  input  grr_pkg::bank_rel_t         rel
);

  import grr_pkg::*;

  localparam int KW = (CW > CFG_W) ? CW : CFG_W;

  typedef struct packed {
    logic          bank;
    logic [CW-1:0] count;
    logic          rev;
    logic          fin;
  } desc_t;

  logic          wr_bank;
  logic [AW-1:0] fill;
  logic [1:0]    busy;
  logic [1:0]    busy_next;
  logic [CW-1:0] n;
  logic [CFG_W-1:0] k;
  logic          full_grp;
  logic          close;
  logic          accept;
  desc_t         d_out;

  assign n        = CW'(fill) + CW'(1);
  assign k        = eff_group(group_size, MAX_GROUP);
  assign full_grp = KW'(n) >= KW'(k);
  assign close    = full_grp || final_in;
  // a bank still draining blocks the writer until it is handed back
  assign in_ready = !busy[wr_bank] && desc_ready;
  assign accept   = in_valid && in_ready;

  assign ram_we    = accept;
  assign ram_waddr = {wr_bank, fill};
  assign ram_wdata = word_in;

  assign desc_valid  = accept && close;
  assign d_out.bank  = wr_bank;
  assign d_out.count = n;
  assign d_out.rev   = full_grp;
  assign d_out.fin   = final_in;
  assign desc        = d_out;

  always_comb begin
    busy_next = busy;
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (accept && close) begin
      busy_next[wr_bank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_bank <= 1'b0;
      fill    <= '0;
      busy    <= '0;
    end else begin
      busy <= busy_next;
      if (accept) begin
        if (close) begin
          fill    <= '0;
          wr_bank <= ~wr_bank;
        end else begin
          fill <= fill + AW'(1);
        end
      end
    end
  end

endmodule

FILE: hw/rtl/grr_back.sv
module grr_back #(
  parameter int WORD_WIDTH = 32,
  parameter int AW         = 4,
  parameter int CW         = 5,
  parameter int DW         = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  desc_valid,
  output logic                  desc_ready,
  input  logic [DW-1:0]         desc,
  output logic                  ram_re,
  output logic [AW:0]           ram_raddr,
  input  logic [WORD_WIDTH-1:0] ram_rdata,
  output grr_pkg::bank_rel_t    rel,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [WORD_WIDTH-1:0] word_out,
  output logic                  final_out
);

  import grr_pkg::*;

  typedef struct packed {
    logic          bank;
    logic [CW-1:0] count;
    logic          rev;
    logic          fin;
  } desc_t;

  desc_t         d_in;
  desc_t         cur;
  logic          act;
  logic [AW-1:0] idx;
  logic [CW-1:0] idx_ext;
  logic          last_rd;
  logic [AW-1:0] addr;
  logic          rd_valid;
  logic          rd_fin;
  logic          load_out;
  logic          adv;
  logic          issue;
  logic          pop;

  assign d_in     = desc_t'(desc);
  assign idx_ext  = CW'(idx);
  assign last_rd  = (idx_ext + CW'(1)) == cur.count;
  assign addr     = cur.rev ? AW'(cur.count - CW'(1) - idx_ext) : idx;

  // output register free, read stage free, then a read may go out
  assign load_out = !out_valid || out_ready;
  assign adv      = !rd_valid || load_out;
  assign issue    = act && adv;

  assign desc_ready = !act || (issue && last_rd);
  assign pop        = desc_valid && desc_ready;

  assign ram_re    = issue;
  assign ram_raddr = {cur.bank, addr};

  assign rel.valid = issue && last_rd;
  assign rel.bank  = cur.bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      act       <= 1'b0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        act <= 1'b1;
      end else if (issue && last_rd) begin
        act <= 1'b0;
      end
      if (adv) begin
        rd_valid <= issue;
      end
      if (load_out) begin
        out_valid <= rd_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= d_in;
      idx <= '0;
    end else if (issue) begin
      idx <= idx + AW'(1);
    end
    if (adv) begin
      rd_fin <= cur.fin && last_rd;
    end
    if (load_out) begin
      word_out  <= ram_rdata;
      final_out <= rd_fin;
    end
  end

endmodule

FILE: hw/rtl/group_reverse_reorder_unit.sv
// group reverse reorder unit
// reverses a stream of words in groups of group_size; a sequence that ends inside
// an unfinished group has that tail passed on in its original order
// s_* channel: input transactions, s_tdata = word_in, s_tlast = final_in
// m_* channel: result transactions, m_tdata = word_out, m_tlast = final_out
// cfg_we / cfg_data: group_size register (reset 2, zero acts as 1, large values
// saturate at MAX_GROUP); write it only while the unit is idle
// the front part writes words into one of two ping-pong banks of a dual-port ram
// and closes a group into a two-entry descriptor queue; the back part drains a
// closed bank, forward or reversed, through a registered read and an output register
// from the transaction that closes a group, its descriptor passes the queue, the drain's
// descriptor register, the registered ram read and the output register to its first result
// the writer fills one bank while the other drains; a bank is handed back with its last
// drain read, and the writer waits for a bank while both are closed
// reset clears the control state only; no clearing pass over the ram is needed
// a stalled m_tready holds the output register, then the read stage, then the
// drain; once both banks wait to be drained s_tready drops
module group_reverse_reorder_unit #(
  parameter int MAX_GROUP  = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_we,
  input  logic [grr_pkg::CFG_W-1:0]                cfg_data,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  input  logic [((WORD_WIDTH + 7) / 8) * 8 - 1:0]  s_tdata,  // word_in, zero pad
  input  logic                                     s_tlast,
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  output logic [((WORD_WIDTH + 7) / 8) * 8 - 1:0]  m_tdata,  // word_out, zero pad
  output logic                                     m_tlast
);

  import grr_pkg::*;

  localparam int TDATA_W = ((WORD_WIDTH + 7) / 8) * 8;
  // index into one bank, and a count that can reach MAX_GROUP
  localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CW = $clog2(MAX_GROUP + 1);
  // descriptor: bank, word count, reverse flag, sequence end flag
  localparam int DW = CW + 3;

  logic [CFG_W-1:0]      group_size;

  logic                  ram_we;
  logic [AW:0]           ram_waddr;
  logic [WORD_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW:0]           ram_raddr;
  logic [WORD_WIDTH-1:0] ram_rdata;

  logic                  push_valid;
  logic                  push_ready;
  logic [DW-1:0]         push_desc;
  logic                  pop_valid;
  logic                  pop_ready;
  logic [DW-1:0]         pop_desc;

  bank_rel_t             rel;
  logic [WORD_WIDTH-1:0] word_out;

  // group size register
  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= GROUP_SIZE_RESET;
    end else if (cfg_we) begin
      group_size <= cfg_data;
    end
  end

  // front: takes transactions, fills a bank, closes groups
  grr_front #(
    .MAX_GROUP  (MAX_GROUP),
    .WORD_WIDTH (WORD_WIDTH),
    .AW         (AW),
    .CW         (CW),
    .DW         (DW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .group_size (group_size),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .word_in    (s_tdata[WORD_WIDTH-1:0]),
    .final_in   (s_tlast),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .desc_valid (push_valid),
    .desc_ready (push_ready),
    .desc       (push_desc),
    .rel        (rel)
  );

  // two ping-pong banks of 2**AW words (at least MAX_GROUP), bank in the top address bit
  grr_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (2 * (2 ** AW))
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // closed groups waiting for the drain
  grr_fifo #(
    .WIDTH (DW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_desc),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_desc)
  );

  // back: drains one closed bank at a time into the output register
  grr_back #(
    .WORD_WIDTH (WORD_WIDTH),
    .AW         (AW),
    .CW         (CW),
    .DW         (DW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (pop_valid),
    .desc_ready (pop_ready),
    .desc       (pop_desc),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .rel        (rel),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .word_out   (word_out),
    .final_out  (m_tlast)
  );

  assign m_tdata = TDATA_W'(word_out);

endmodule

FILE: hw/rtl/grr_checker.sv
module grr_checker #(
  parameter int TDW = 32
) (
  input logic           clk,
  input logic           rst,
  input logic           s_tready,
  input logic           m_tvalid,
  input logic           m_tready,
  input logic [TDW-1:0] m_tdata,
  input logic           m_tlast
);

`include "assert_macros.svh"

  // a stalled result transaction stays offered
  `GRR_ASSERT_ON(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid)

  // and keeps its payload
  `GRR_ASSERT_ON(a_out_stable, clk, rst, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))

  // reset empties the output and opens the input side
  `GRR_ASSERT_ALL(a_reset_state, clk, rst |=> !m_tvalid && s_tready)

  // no result can come out right after reset, before any word has gone through
  `GRR_ASSERT_ALL(a_reset_latency, clk, rst ##1 1'b1 |=> !m_tvalid)

endmodule

bind group_reverse_reorder_unit grr_checker #(.TDW(TDATA_W)) u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_GROUP  = 16;
  localparam int WORD_WIDTH = 32;
  localparam int DATA_W     = ((WORD_WIDTH + 7) / 8) * 8;
  localparam int SETTLE     = 8;    // cycles past the last result before a register write
  localparam int HOLD_LEN   = 80;   // long receiver hold-off, in cycles
  localparam int PHASE_LEN  = 10;   // minimum random transactions per group size setting

  typedef logic [WORD_WIDTH-1:0] word_t;

  typedef struct {
    word_t word;
    logic  last;
  } out_word_t;

  // tracks the buffered group and the words the unit owes on its output
  class reorder_scoreboard;
    word_t                   held [MAX_GROUP];
    int                      fill;
    logic [grr_pkg::CFG_W-1:0] group_size;
    out_word_t               owed [$];
    int                      errors;

    function new();
      fill       = 0;
      group_size = grr_pkg::GROUP_SIZE_RESET;
      errors     = 0;
    endfunction

    function void set_group_size(input logic [grr_pkg::CFG_W-1:0] gs);
      group_size = gs;
    endfunction

    // accepted input transaction: buffer it, release a group when due
    function void take_word(input word_t w, input logic last);
      int        k;
      out_word_t e;
      k = int'(group_size);
      if (k < 1) begin
        k = 1;
      end else if (k > MAX_GROUP) begin
        k = MAX_GROUP;
      end
      if (fill < MAX_GROUP) begin
        held[fill] = w;
        fill++;
      end
      if (fill >= k) begin
        // full group (or more after k was lowered): newest word first
        for (int i = fill - 1; i >= 0; i--) begin
          e.word = held[i];
          e.last = last && (i == 0);
          owed.push_back(e);
        end
        fill = 0;
      end else if (last) begin
        // sequence ends inside a group: tail goes out in arrival order
        for (int i = 0; i < fill; i++) begin
          e.word = held[i];
          e.last = last && (i == fill - 1);
          owed.push_back(e);
        end
        fill = 0;
      end
    endfunction

    // accepted output transaction against the oldest owed word
    function void check_word(input word_t w, input logic last);
      out_word_t e;
      if (owed.size() == 0) begin
        $error("unexpected result transaction: word_out %h final_out %b", w, last);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (w !== e.word) begin
        $error("word_out mismatch: expected %h actual %h", e.word, w);
        errors++;
      end
      if (last !== e.last) begin
        $error("final_out mismatch: expected %b actual %b", e.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [grr_pkg::CFG_W-1:0] cfg_data = '0;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [DATA_W-1:0]         s_tdata = '0;   // word_in
  logic                      s_tlast = 1'b0; // final_in
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [DATA_W-1:0]         m_tdata;        // word_out
  logic                      m_tlast;        // final_out

  reorder_scoreboard sb = new();

  int burst_left = 0;
  bit hold_request = 1'b0;

  group_reverse_reorder_unit #(
    .MAX_GROUP (MAX_GROUP),
    .WORD_WIDTH(WORD_WIDTH)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: every accepted transaction is checked at the rising edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_word(m_tdata[WORD_WIDTH-1:0], m_tlast);
    end
  end

  // receiver: changing stall patterns, plus a long hold-off on request
  initial begin
    int mode;
    int mode_left;
    int held_cycles;
    mode = 0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        m_tready = 1'b0;
        held_cycles = 0;
        while (held_cycles < HOLD_LEN) begin
          @(negedge clk);
          held_cycles++;
        end
        hold_request = 1'b0;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(8, 40);
      end
      mode_left--;
      case (mode)
        0: m_tready = 1'b1;                              // no stalls at all
        1: m_tready = 1'($urandom_range(0, 1));          // coin toss
        2: m_tready = ($urandom_range(0, 3) != 0);       // occasional stall
        default: m_tready = (mode_left % 3 == 0);        // mostly stalled
      endcase
    end
  end

  // hard limit on run time
  initial begin
    #500us;
    $display("FAIL");
    $finish;
  end

  function automatic word_t pick_word();
    case ($urandom_range(0, 7))
      0: return {1'b1, {(WORD_WIDTH-1){1'b0}}};  // most negative
      1: return {1'b0, {(WORD_WIDTH-1){1'b1}}};  // most positive
      2: return '0;
      3: return '1;
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic int clamp_group(input int gs);
    if (gs < 1) return 1;
    if (gs > MAX_GROUP) return MAX_GROUP;
    return gs;
  endfunction

  // one input transaction; entered and left just after a falling edge
  task automatic send_word(input word_t w, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_tvalid = 1'b1;
    s_tdata  = DATA_W'(w);
    s_tlast  = last;
    do @(posedge clk); while (!s_tready);
    sb.take_word(w, last);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic send_sequence(input int len);
    for (int i = 0; i < len; i++) begin
      send_word(pick_word(), i == len - 1);
    end
  endtask

  // register write once the unit has nothing left to deliver
  task automatic write_group_size(input logic [grr_pkg::CFG_W-1:0] gs);
    int waited;
    s_tvalid = 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE) @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = gs;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_group_size(gs);
    burst_left = 0;
  endtask

  // random sequences under one setting, mostly whole groups plus a tail
  task automatic random_phase(input logic [grr_pkg::CFG_W-1:0] gs,
                              input bit hold_off = 1'b0);
    int k;
    int sent;
    int len;
    k = clamp_group(int'(gs));
    write_group_size(gs);
    // receiver holds off while this phase keeps sending, input backs up
    if (hold_off) begin
      hold_request = 1'b1;
    end
    sent = 0;
    while (sent < PHASE_LEN) begin
      if ($urandom_range(0, 3) != 0) begin
        len = k * (k > 8 ? 1 : $urandom_range(1, 2));
        if ($urandom_range(0, 1) == 1) len += $urandom_range(0, k - 1);
      end else begin
        len = $urandom_range(1, 2 * k);
      end
      send_sequence(len);
      sent += len;
    end
  endtask

  initial begin
    int waited;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part, group size 2 out of reset
    send_word({1'b0, {(WORD_WIDTH-1){1'b1}}}, 1'b0);
    send_word({1'b1, {(WORD_WIDTH-1){1'b0}}}, 1'b0);  // full group, reversed
    send_word('1, 1'b0);
    send_word('0, 1'b1);                               // last word closes a group
    send_word(word_t'(32'h1234_5678), 1'b1);           // lone tail at sequence end

    write_group_size(grr_pkg::CFG_W'(4));
    send_word(word_t'(32'hA5A5_A5A5), 1'b0);
    send_word(word_t'(32'h5A5A_5A5A), 1'b0);
    send_word(word_t'(32'h0000_0001), 1'b1);          // unfinished group, in order

    write_group_size('0);                              // zero acts as one
    send_word(word_t'(32'hDEAD_BEEF), 1'b0);
    send_word(word_t'(32'hFFFF_FFFE), 1'b1);

    // group size lowered below the count already buffered
    write_group_size(grr_pkg::CFG_W'(8));
    for (int i = 0; i < 5; i++) begin
      send_word(pick_word(), 1'b0);
    end
    write_group_size(grr_pkg::CFG_W'(3));
    send_word(pick_word(), 1'b1);

    // random part over a range of settings
    random_phase(grr_pkg::CFG_W'(31));                 // saturates at the maximum
    random_phase(grr_pkg::CFG_W'(1));
    random_phase(grr_pkg::CFG_W'(3), 1'b1);            // with a long receiver hold-off
    random_phase(grr_pkg::CFG_W'(16));
    random_phase(grr_pkg::CFG_W'(17));
    random_phase(grr_pkg::CFG_W'($urandom_range(2, 15)));
    random_phase(grr_pkg::CFG_W'($urandom_range(0, 31)));

    // drain
    s_tvalid = 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (20) @(negedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected result transactions never arrived", sb.pending());
      sb.errors++;
    end

    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
